// ----- design/punrank_pkg.sv -----
package punrank_pkg;

  // fixed field widths
  localparam int unsigned RANK_W  = 41;
  localparam int unsigned VALUE_W = 4;
  localparam int unsigned INDEX_W = 4;

  // default board side
  localparam int unsigned BOARD_SIDE_DEF = 4;

  // factorial lookup, 15! still fits the rank width
  function automatic logic [RANK_W-1:0] fact_f(input logic [INDEX_W-1:0] n);
    logic [RANK_W-1:0] f;
    case (n)
      4'd0:    f = 41'd1;
      4'd1:    f = 41'd1;
      4'd2:    f = 41'd2;
      4'd3:    f = 41'd6;
      4'd4:    f = 41'd24;
      4'd5:    f = 41'd120;
      4'd6:    f = 41'd720;
      4'd7:    f = 41'd5040;
      4'd8:    f = 41'd40320;
      4'd9:    f = 41'd362880;
      4'd10:   f = 41'd3628800;
      4'd11:   f = 41'd39916800;
      4'd12:   f = 41'd479001600;
      4'd13:   f = 41'd6227020800;
      4'd14:   f = 41'd87178291200;
      4'd15:   f = 41'd1307674368000;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ----- design/permutation_unrank.sv -----
// channel | valid      | stall       | payload
// --------+------------+-------------+--------------------------------------------------
// in      | in_valid_i | in_stall_o  | rank_i
// out     | out_valid_o| out_stall_i | cell_value_o, cell_index_o, last_cell_o, rank_error_o
//
// one rank request gives BOARD_SIDE*BOARD_SIDE cell requests in row-major order
// each tile cell resolves clog2(tiles) quotient bits, a restoring quotient step per bit on
// the one shared 45-bit compare/subtract unit, then emits the cell; the blank is only emitted
// an out-of-range rank skips the divider and emits one cell per cycle while the output is not stalled
// async active-low reset empties the output register and returns to idle
// a stalled output register holds the sequencer in its emit state
module permutation_unrank #(
  parameter int unsigned BOARD_SIDE = punrank_pkg::BOARD_SIDE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [punrank_pkg::RANK_W-1:0]    rank_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [punrank_pkg::VALUE_W-1:0]   cell_value_o,
  output logic [punrank_pkg::INDEX_W-1:0]   cell_index_o,
  output logic                              last_cell_o,
  output logic                              rank_error_o
);
  import punrank_pkg::*;

  localparam int unsigned CELL_COUNT = BOARD_SIDE * BOARD_SIDE;
  localparam int unsigned TILE_COUNT = CELL_COUNT - 1;
  // quotient bits: the first quotient is at most TILE_COUNT-1
  localparam int unsigned QW = $clog2(TILE_COUNT);
  localparam int unsigned SW = (QW > 1) ? $clog2(QW) : 1;
  localparam int unsigned DW = RANK_W + QW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                  state_q;
  logic [RANK_W-1:0]       rest_q;      // remaining rank
  logic                    bad_q;
  logic [INDEX_W-1:0]      pos_q;       // current cell
  logic [SW-1:0]           step_q;      // quotient bit being resolved
  logic [QW-1:0]           q_q;
  logic [RANK_W-1:0]       fact_q;      // divisor for the current cell
  logic [VALUE_W-1:0]      list_q [TILE_COUNT];  // unused values, ascending

  logic                    out_valid_q;
  logic [VALUE_W-1:0]      cell_value_q;
  logic [INDEX_W-1:0]      cell_index_q;
  logic                    last_cell_q;
  logic                    rank_error_q;

  // shared divider datapath
  logic [DW-1:0]           trial;
  logic [DW-1:0]           rest_ext;
  logic                    fits;
  logic [RANK_W-1:0]       rest_d;
  logic                    rank_bad;
  logic [VALUE_W-1:0]      pick;
  logic                    out_free;
  logic                    is_tile;
  logic                    is_last;
  logic                    next_is_tile;

  always_comb begin
    trial        = DW'(fact_q) << step_q;
    rest_ext     = DW'(rest_q);
    fits         = rest_ext >= trial;
    rest_d       = RANK_W'(rest_ext - trial);
    rank_bad     = rank_i >= fact_f(INDEX_W'(TILE_COUNT));
    pick         = list_q[q_q];
    out_free     = !out_valid_q || !out_stall_i;
    is_tile      = pos_q < INDEX_W'(TILE_COUNT);
    is_last      = pos_q == INDEX_W'(CELL_COUNT - 1);
    next_is_tile = pos_q < INDEX_W'(TILE_COUNT - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rest_q       <= '0;
      bad_q        <= 1'b0;
      pos_q        <= '0;
      step_q       <= '0;
      q_q          <= '0;
      fact_q       <= '0;
      for (int i = 0; i < TILE_COUNT; i++) begin
        list_q[i] <= '0;
      end
      out_valid_q  <= 1'b0;
      cell_value_q <= '0;
      cell_index_q <= '0;
      last_cell_q  <= 1'b0;
      rank_error_q <= 1'b0;
    end else begin
      // the emit state refills the output register itself
      if (!out_stall_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            rest_q <= rank_i;
            bad_q  <= rank_bad;
            pos_q  <= '0;
            q_q    <= '0;
            step_q <= SW'(QW - 1);
            fact_q <= fact_f(INDEX_W'(TILE_COUNT - 1));
            for (int i = 0; i < TILE_COUNT; i++) begin
              list_q[i] <= VALUE_W'(i + 1);
            end
            state_q <= rank_bad ? ST_EMIT : ST_DIV;
          end
        end
        ST_DIV: begin
          // one restoring quotient bit per cycle
          if (fits) begin
            rest_q      <= rest_d;
            q_q[step_q] <= 1'b1;
          end
          if (step_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            step_q <= step_q - SW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            cell_value_q <= (bad_q || !is_tile) ? '0 : pick;
            cell_index_q <= pos_q;
            last_cell_q  <= is_last;
            rank_error_q <= bad_q;
            // drop the chosen value, close the gap
            if (is_tile && !bad_q) begin
              for (int i = 0; i < TILE_COUNT; i++) begin
                if (QW'(i) >= q_q) begin
                  list_q[i] <= (i + 1 < TILE_COUNT) ? list_q[(i + 1) % TILE_COUNT] : '0;
                end
              end
            end
            if (is_last) begin
              state_q <= ST_IDLE;
            end else begin
              pos_q <= pos_q + INDEX_W'(1);
              if (!bad_q && next_is_tile) begin
                q_q     <= '0;
                step_q  <= SW'(QW - 1);
                fact_q  <= fact_f(INDEX_W'(TILE_COUNT - 2) - pos_q);
                state_q <= ST_DIV;
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign cell_value_o = cell_value_q;
  assign cell_index_o = cell_index_q;
  assign last_cell_o  = last_cell_q;
  assign rank_error_o = rank_error_q;

`ifndef SYNTHESIS
  // an out-of-range rank never shows a tile
  a_error_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rank_error_o |-> cell_value_o == '0)
    else $error("tile value on an out-of-range rank");

  // the final cell is always the blank
  a_last_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_cell_o |-> cell_value_o == '0)
    else $error("final cell not blank");

  // when a new rank can be taken only the final cell may still be pending
  a_idle_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && out_valid_o |-> last_cell_o)
    else $error("ready while a board is still being emitted");

  // a taken rank keeps the input stalled while it is decoded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a rank was taken");
`endif

endmodule
